// File: hw/rtl/tti_pkg.sv
// Shared types, constants and helper functions of the text to integer parser.
package tti_pkg;

    // Field widths fixed by the item formats.
    localparam int TEXT_W   = 8;
    localparam int RADIX_W  = 6;
    localparam int NUMBER_W = 64;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 9;

    // Default longest string that advances the byte position.
    localparam int TTI_MAX_TEXT_LENGTH = 256;

    // Radix codes.
    localparam logic [RADIX_W-1:0] RADIX_AUTO    = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_ONE     = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_OCTAL   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DECIMAL = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX     = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;

    // Digit value given to a byte that is no digit at all.
    localparam logic [RADIX_W-1:0] DIGIT_NONE = 6'd36;

    // Character codes.
    localparam logic [TEXT_W-1:0] CH_NUL     = 8'h00;
    localparam logic [TEXT_W-1:0] CH_PAST    = 8'h01;
    localparam logic [TEXT_W-1:0] CH_TAB     = 8'h09;
    localparam logic [TEXT_W-1:0] CH_CR      = 8'h0D;
    localparam logic [TEXT_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [TEXT_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [TEXT_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [TEXT_W-1:0] CH_DIGIT0  = 8'h30;
    localparam logic [TEXT_W-1:0] CH_DIGIT9  = 8'h39;
    localparam logic [TEXT_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [TEXT_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [TEXT_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [TEXT_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [TEXT_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [TEXT_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [TEXT_W-1:0] DIGIT_TEN  = 8'd10;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_BAD_RADIX = 2'd2
    } t_status;

    // Parse phases of one string.
    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    // Radix that a digit is checked against in the current byte.
    typedef enum logic [1:0] {
        RS_KEEP,
        RS_DECIMAL,
        RS_OCTAL,
        RS_HEX
    } t_radix_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       feed;
        logic       finish;
        t_radix_sel radix_sel;
        logic       digit_try;
        logic       set_minus;
        logic       set_zero;
        logic       clr_zero;
        logic       mark_zero_end;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stage_free;
        logic is_nul;
        logic is_final;
        logic is_space;
        logic is_minus;
        logic is_plus;
        logic is_zero_char;
        logic is_x;
        logic radix_bad;
        logic radix_auto;
        logic digit_ok;
    } t_sts;

    // Digit value of a character, DIGIT_NONE for anything else.
    function automatic logic [RADIX_W-1:0] digit_value(input logic [TEXT_W-1:0] c);
        logic [RADIX_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
            d = RADIX_W'(c - CH_DIGIT0);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d = RADIX_W'(c - CH_LOWER_A + DIGIT_TEN);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d = RADIX_W'(c - CH_UPPER_A + DIGIT_TEN);
        end
        return d;
    endfunction

    // A radix of one or above thirty-six cannot be used.
    function automatic logic radix_invalid(input logic [RADIX_W-1:0] r);
        return (r == RADIX_ONE) || (r > RADIX_MAX);
    endfunction

endpackage

// File: hw/rtl/tti_if.sv
// Handshake interfaces of the text input, result output and radix configuration channels.
interface tti_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface tti_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] number;
    logic [1:0]  status;
    logic [8:0]  stop_offset;

    modport source (output valid, output number, output status, output stop_offset,
                    input ready);
    modport sink   (input valid, input number, input status, input stop_offset,
                    output ready);
endinterface

interface tti_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

// File: hw/rtl/tti_ctrl.sv
// Parse phase state machine that sequences the datapath byte by byte.
module tti_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  tti_pkg::t_sts i_sts,
    output tti_pkg::t_cmd o_cmd
);
    import tti_pkg::*;

    t_phase r_phase;
    t_phase n_phase;

    // Phase register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Next phase for an accepted byte.
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_sts.is_nul || i_sts.is_final) begin
                n_phase = PH_SPACE;
            end else begin
                unique case (r_phase)
                    PH_SPACE, PH_SIGNED: begin
                        if (r_phase == PH_SPACE && i_sts.is_space) begin
                            n_phase = PH_SPACE;
                        end else if (r_phase == PH_SPACE && (i_sts.is_minus || i_sts.is_plus)) begin
                            n_phase = PH_SIGNED;
                        end else if (i_sts.radix_bad) begin
                            n_phase = PH_DONE;
                        end else if (i_sts.radix_auto && i_sts.is_zero_char) begin
                            n_phase = PH_ZERO;
                        end else begin
                            n_phase = i_sts.digit_ok ? PH_DIGITS : PH_DONE;
                        end
                    end
                    PH_ZERO: begin
                        if (i_sts.is_x) begin
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = i_sts.digit_ok ? PH_DIGITS : PH_DONE;
                        end
                    end
                    PH_DIGITS: begin
                        n_phase = i_sts.digit_ok ? PH_DIGITS : PH_DONE;
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
    end

    // Datapath commands for an accepted byte.
    always_comb begin
        o_cmd           = '0;
        o_cmd.radix_sel = RS_KEEP;
        if (i_accept) begin
            o_cmd.feed   = !i_sts.is_nul;
            o_cmd.finish = i_sts.is_nul || i_sts.is_final;
            if (!i_sts.is_nul) begin
                unique case (r_phase)
                    PH_SPACE, PH_SIGNED: begin
                        if (r_phase == PH_SPACE && i_sts.is_space) begin
                            o_cmd.digit_try = 1'b0;
                        end else if (r_phase == PH_SPACE && i_sts.is_minus) begin
                            o_cmd.set_minus = 1'b1;
                        end else if (r_phase == PH_SPACE && i_sts.is_plus) begin
                            o_cmd.digit_try = 1'b0;
                        end else if (i_sts.radix_bad) begin
                            o_cmd.digit_try = 1'b0;
                        end else if (i_sts.radix_auto) begin
                            if (i_sts.is_zero_char) begin
                                o_cmd.set_zero      = 1'b1;
                                o_cmd.mark_zero_end = 1'b1;
                            end else begin
                                o_cmd.radix_sel = RS_DECIMAL;
                                o_cmd.digit_try = 1'b1;
                            end
                        end else begin
                            o_cmd.digit_try = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        if (i_sts.is_x) begin
                            o_cmd.radix_sel = RS_HEX;
                            o_cmd.clr_zero  = 1'b1;
                        end else begin
                            o_cmd.radix_sel = RS_OCTAL;
                            o_cmd.digit_try = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        o_cmd.digit_try = 1'b1;
                    end
                    default: begin
                        o_cmd.digit_try = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

// File: hw/rtl/tti_datapath.sv
// Character classifier, accumulator, string state, finish stage and output register.
module tti_datapath #(
    parameter int MAX_TEXT_LENGTH = tti_pkg::TTI_MAX_TEXT_LENGTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tti_pkg::TEXT_W-1:0]    i_text_byte,
    input  logic                          i_final_byte,
    input  logic                          i_cfg_we,
    input  logic [tti_pkg::RADIX_W-1:0]   i_cfg_radix,
    input  tti_pkg::t_cmd                 i_cmd,
    output tti_pkg::t_sts                 o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [tti_pkg::NUMBER_W-1:0]  o_number,
    output logic [tti_pkg::STATUS_W-1:0]  o_status,
    output logic [tti_pkg::OFFSET_W-1:0]  o_stop_offset
);
    import tti_pkg::*;

    localparam int PW = $clog2(MAX_TEXT_LENGTH + 1);
    localparam int PROD_W = NUMBER_W + RADIX_W;
    localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_TEXT_LENGTH);

    // Configuration and per-string state.
    logic [RADIX_W-1:0]  r_radix;
    logic [RADIX_W-1:0]  r_active_radix;
    logic [NUMBER_W-1:0] r_acc;
    logic                r_minus;
    logic                r_lead_zero;
    logic                r_any_digit;
    logic                r_ovf;
    logic [PW-1:0]       r_position;
    logic [PW-1:0]       r_end;

    // Finish stage and output register.
    logic                r_fin_valid;
    logic [NUMBER_W-1:0] r_fin_acc;
    logic                r_fin_minus;
    t_status             r_fin_status;
    logic [OFFSET_W-1:0] r_fin_off;
    logic                r_out_valid;
    logic [NUMBER_W-1:0] r_out_number;
    t_status             r_out_status;
    logic [OFFSET_W-1:0] r_out_off;

    logic [RADIX_W-1:0]  n_active_radix;
    logic [NUMBER_W-1:0] n_acc;
    logic                n_minus;
    logic                n_lead_zero;
    logic                n_any_digit;
    logic                n_ovf;
    logic [PW-1:0]       n_position;
    logic [PW-1:0]       n_end;
    t_status             n_fin_status;
    logic [PW-1:0]       n_fin_off;

    logic                first_byte;
    logic                pos_full;
    logic [RADIX_W-1:0]  eff_radix;
    logic [RADIX_W-1:0]  dig_radix;
    logic [TEXT_W-1:0]   c_feed;
    logic [RADIX_W-1:0]  digit;
    logic                digit_ok;
    logic                take;
    logic [PROD_W-1:0]   mul_sum;
    logic                mul_ovf;
    logic                radix_bad;
    logic                out_free;
    logic                stage_free;
    logic                fin_move;

    // Radix in force: the configured one is latched at the first byte of a string.
    assign first_byte = (r_position == '0);
    assign pos_full   = (r_position >= POS_LIMIT);
    assign eff_radix  = first_byte ? r_radix : r_active_radix;
    assign radix_bad  = radix_invalid(eff_radix);

    // Bytes past the length limit behave as a non-digit.
    assign c_feed = pos_full ? CH_PAST : i_text_byte;
    assign digit  = digit_value(c_feed);

    always_comb begin
        unique case (i_cmd.radix_sel)
            RS_KEEP:    dig_radix = eff_radix;
            RS_DECIMAL: dig_radix = RADIX_DECIMAL;
            RS_OCTAL:   dig_radix = RADIX_OCTAL;
            RS_HEX:     dig_radix = RADIX_HEX;
            default:    dig_radix = eff_radix;
        endcase
    end

    assign digit_ok = (digit < dig_radix);
    assign take     = i_cmd.digit_try && digit_ok;

    // Multiply-add with the carry bits above 64 showing overflow.
    assign mul_sum = PROD_W'(r_acc) * PROD_W'(dig_radix) + PROD_W'(digit);
    assign mul_ovf = |mul_sum[PROD_W-1:NUMBER_W];

    // Next string state for the current byte.
    always_comb begin
        n_active_radix = dig_radix;
        n_acc          = r_acc;
        n_ovf          = r_ovf;
        if (take && !r_ovf) begin
            if (mul_ovf) begin
                n_ovf = 1'b1;
            end else begin
                n_acc = mul_sum[NUMBER_W-1:0];
            end
        end
        n_any_digit = r_any_digit | take;
        n_minus     = r_minus | i_cmd.set_minus;
        n_lead_zero = i_cmd.set_zero ? 1'b1 : (i_cmd.clr_zero ? 1'b0 : r_lead_zero);
        n_end       = (take || i_cmd.mark_zero_end) ? r_position + 1'b1 : r_end;
        n_position  = (i_cmd.feed && !pos_full) ? r_position + 1'b1 : r_position;
    end

    // Status and stop offset of a finishing string.
    always_comb begin
        if (radix_bad) begin
            n_fin_status = ST_BAD_RADIX;
            n_fin_off    = '0;
        end else if (n_ovf) begin
            n_fin_status = ST_OVERFLOW;
            n_fin_off    = n_end;
        end else begin
            n_fin_status = ST_OK;
            n_fin_off    = (n_any_digit || n_lead_zero) ? n_end : '0;
        end
    end

    // Radix register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_AUTO;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_radix;
        end
    end

    // String state: cleared when a string finishes, updated on each fed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.finish) begin
            r_active_radix <= RADIX_AUTO;
            r_acc          <= '0;
            r_minus        <= 1'b0;
            r_lead_zero    <= 1'b0;
            r_any_digit    <= 1'b0;
            r_ovf          <= 1'b0;
            r_position     <= '0;
            r_end          <= '0;
        end else if (i_cmd.feed) begin
            r_active_radix <= n_active_radix;
            r_acc          <= n_acc;
            r_minus        <= n_minus;
            r_lead_zero    <= n_lead_zero;
            r_any_digit    <= n_any_digit;
            r_ovf          <= n_ovf;
            r_position     <= n_position;
            r_end          <= n_end;
        end
    end

    // Finish stage hands over to the output register when that is free.
    assign out_free   = !r_out_valid || i_out_ready;
    assign fin_move   = r_fin_valid && out_free;
    assign stage_free = !r_fin_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_fin_valid <= 1'b1;
            end else if (fin_move) begin
                r_fin_valid <= 1'b0;
            end
            if (fin_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_fin_acc    <= n_acc;
            r_fin_minus  <= n_minus;
            r_fin_status <= n_fin_status;
            r_fin_off    <= OFFSET_W'(n_fin_off);
        end
    end

    // Sign and error handling of the value into the output register.
    always_ff @(posedge i_clk) begin
        if (fin_move) begin
            if (r_fin_status != ST_OK) begin
                r_out_number <= '0;
            end else if (r_fin_minus) begin
                r_out_number <= '0 - r_fin_acc;
            end else begin
                r_out_number <= r_fin_acc;
            end
            r_out_status <= r_fin_status;
            r_out_off    <= r_fin_off;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_number      = r_out_number;
    assign o_status      = r_out_status;
    assign o_stop_offset = r_out_off;

    // Status toward the controller.
    always_comb begin
        o_sts              = '0;
        o_sts.stage_free   = stage_free;
        o_sts.is_nul       = (i_text_byte == CH_NUL);
        o_sts.is_final     = i_final_byte;
        o_sts.is_space     = (c_feed == CH_SPACE) || (c_feed >= CH_TAB && c_feed <= CH_CR);
        o_sts.is_minus     = (c_feed == CH_MINUS);
        o_sts.is_plus      = (c_feed == CH_PLUS);
        o_sts.is_zero_char = (c_feed == CH_DIGIT0);
        o_sts.is_x         = (c_feed == CH_LOWER_X) || (c_feed == CH_UPPER_X);
        o_sts.radix_bad    = radix_bad;
        o_sts.radix_auto   = (eff_radix == RADIX_AUTO);
        o_sts.digit_ok     = digit_ok;
    end

    // The byte position never runs past the length limit.
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= POS_LIMIT)
        else $error("byte position beyond the length limit");

    // The stop offset never lies past the bytes taken.
    a_end_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_end <= r_position)
        else $error("stop offset ahead of byte position");

    // A finishing string leaves a result in the finish stage and clean state.
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_fin_valid && r_position == '0 && !r_ovf))
        else $error("finished string not staged or not cleared");

    // Digits are only ever taken under a resolved, usable radix.
    a_digit_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any_digit |-> (r_active_radix != RADIX_AUTO && !radix_invalid(r_active_radix)))
        else $error("digit taken under an unusable radix");

endmodule

// File: hw/rtl/text_to_integer_parser.sv
// Top level of the streaming text to unsigned 64-bit integer parser.
//
// Usage: a string arrives on i_text one byte per item, ended by a NUL byte or by an item
// with final_byte set. Leading whitespace and one sign are skipped, then digits are taken
// in the radix from i_cfg (0 picks hex after 0x, octal after a leading 0, else decimal).
// One result item per string comes out on o_result: number, status (ok, overflow, bad
// radix) and stop_offset. The radix is sampled at the first byte of each string; write
// i_cfg only between strings. i_cfg is always ready.
// Throughput: one byte per cycle while the finish stage is free; every byte passes the
// 64 by 6 bit multiply-add of the accumulator in the cycle that accepts it, so there is no
// gap between strings either. A result passes the finish stage for the status, then
// the output register for sign and error handling.
// Reset: the radix returns to auto, the string state clears and no result is pending.
// Stall: a result waits in the output register while o_result.ready is low, and a second
// one can wait in the finish stage; i_text stops taking bytes only when both are full.
module text_to_integer_parser #(
    parameter int MAX_TEXT_LENGTH = tti_pkg::TTI_MAX_TEXT_LENGTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tti_text_if.sink            i_text,
    tti_result_if.source        o_result,
    tti_cfg_if.sink             i_cfg
);
    import tti_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_accept;

    // Input handshake: bytes are taken whenever the finish stage can hold a result.
    assign i_text.ready = w_sts.stage_free;
    assign w_accept     = i_text.valid && i_text.ready;
    assign i_cfg.ready  = 1'b1;

    tti_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    tti_datapath #(
        .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_text_byte   (i_text.text_byte),
        .i_final_byte  (i_text.final_byte),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_radix   (i_cfg.radix),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (o_result.valid),
        .o_number      (o_result.number),
        .o_status      (o_result.status),
        .o_stop_offset (o_result.stop_offset)
    );

endmodule

// File: tb/sv/text_to_integer_parser_test.sv
// Self-checking testbench of the streaming text to integer parser.
`timescale 1ns / 100ps

module text_to_integer_parser_test;
    import tti_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 10;
    // Cycles to let pass after the last result before a radix write or the end.
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 60;

    // One result item as the parser reports it.
    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] stop_offset;
    } t_parse_result;

    // One row of the directed table: a text item or a radix write.
    typedef enum {ROW_TEXT, ROW_RADIX} t_row_kind;
    typedef struct {
        t_row_kind     kind;
        logic [7:0]    value;
        bit            fin;
        bit            typed;
        t_parse_result want;
    } t_row;

    logic clk;
    logic rst_n;

    tti_text_if   text_ch();
    tti_result_if result_ch();
    tti_cfg_if    cfg_ch();

    text_to_integer_parser dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_text   (text_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // Parser state as the testbench tracks it.
    logic [RADIX_W-1:0]  radix_reg;
    t_phase              parse_phase;
    logic [RADIX_W-1:0]  parse_base;
    logic [NUMBER_W-1:0] parse_acc;
    bit                  saw_minus;
    bit                  saw_zero;
    bit                  saw_digit;
    bit                  saw_overflow;
    logic [OFFSET_W-1:0] text_pos;
    logic [OFFSET_W-1:0] end_pos;

    t_parse_result awaited_numbers[$];
    t_row          directed_rows[$];
    int            mismatch_count;
    int            text_items;
    int            burst_left;
    bit            steady_send;

    // Clock.
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Run limit.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Value of a character as a digit; 36 means no digit at all.
    function automatic logic [RADIX_W-1:0] char_digit(input logic [7:0] c);
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
            return RADIX_W'(c - CH_DIGIT0);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            return RADIX_W'(c - CH_LOWER_A) + RADIX_W'(10);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return RADIX_W'(c - CH_UPPER_A) + RADIX_W'(10);
        end
        return RADIX_MAX;
    endfunction

    function automatic bit base_unusable(input logic [RADIX_W-1:0] r);
        return (r == RADIX_ONE) || (r > RADIX_MAX);
    endfunction

    // Clear everything that belongs to one string.
    task automatic clear_parse();
        parse_phase  = PH_SPACE;
        parse_base   = RADIX_AUTO;
        parse_acc    = '0;
        saw_minus    = 1'b0;
        saw_zero     = 1'b0;
        saw_digit    = 1'b0;
        saw_overflow = 1'b0;
        text_pos     = '0;
        end_pos      = '0;
    endtask

    // Accumulate one digit, or end parsing at a byte that is no digit in this base.
    task automatic accumulate_digit(input logic [7:0] c, input logic [OFFSET_W-1:0] pos);
        logic [RADIX_W-1:0] d;
        logic [71:0]        wide;
        d = char_digit(c);
        if (d >= parse_base || parse_base == RADIX_AUTO) begin
            parse_phase = PH_DONE;
        end else begin
            saw_digit = 1'b1;
            if (!saw_overflow) begin
                wide = 72'(parse_acc) * 72'(parse_base) + 72'(d);
                if (wide[71:64] != 8'd0) begin
                    saw_overflow = 1'b1;
                end else begin
                    parse_acc = wide[63:0];
                end
            end
            end_pos = pos + 9'd1;
        end
    endtask

    // First byte after the whitespace and the sign.
    task automatic start_number(input logic [7:0] c, input logic [OFFSET_W-1:0] pos);
        if (base_unusable(parse_base)) begin
            parse_phase = PH_DONE;
        end else if (parse_base == RADIX_AUTO) begin
            if (c == CH_DIGIT0) begin
                parse_phase = PH_ZERO;
                saw_zero    = 1'b1;
                end_pos     = pos + 9'd1;
            end else begin
                parse_base  = RADIX_DECIMAL;
                parse_phase = PH_DIGITS;
                accumulate_digit(c, pos);
            end
        end else begin
            parse_phase = PH_DIGITS;
            accumulate_digit(c, pos);
        end
    endtask

    task automatic parse_feed(input logic [7:0] c, input logic [OFFSET_W-1:0] pos);
        case (parse_phase)
            PH_SPACE: begin
                if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                    if (c == CH_MINUS) begin
                        saw_minus   = 1'b1;
                        parse_phase = PH_SIGNED;
                    end else if (c == CH_PLUS) begin
                        parse_phase = PH_SIGNED;
                    end else begin
                        start_number(c, pos);
                    end
                end
            end
            PH_SIGNED: begin
                start_number(c, pos);
            end
            PH_ZERO: begin
                if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                    parse_base  = RADIX_HEX;
                    saw_zero    = 1'b0;
                    parse_phase = PH_DIGITS;
                end else begin
                    parse_base  = RADIX_OCTAL;
                    parse_phase = PH_DIGITS;
                    accumulate_digit(c, pos);
                end
            end
            PH_DIGITS: begin
                accumulate_digit(c, pos);
            end
            default: begin
            end
        endcase
    endtask

    // Take one accepted text item; at the end of a string, give the expected result.
    task automatic parse_step(input logic [7:0] c, input bit fin,
                              output bit done, output t_parse_result r);
        // The radix register counts from the first byte of each string.
        if (text_pos == 0 && parse_phase == PH_SPACE && !saw_minus) begin
            parse_base = radix_reg;
        end
        if (c != CH_NUL) begin
            if (int'(text_pos) < TTI_MAX_TEXT_LENGTH) begin
                parse_feed(c, text_pos);
                text_pos = text_pos + 9'd1;
            end else begin
                // Bytes past the length limit stop parsing like a non-digit.
                parse_feed(CH_PAST, text_pos);
            end
        end
        done = (c == CH_NUL) || fin;
        r    = '0;
        if (done) begin
            if (base_unusable(parse_base)) begin
                r.status = ST_BAD_RADIX;
            end else if (saw_overflow) begin
                r.status      = ST_OVERFLOW;
                r.stop_offset = end_pos;
            end else begin
                r.number      = saw_minus ? 64'd0 - parse_acc : parse_acc;
                r.status      = ST_OK;
                r.stop_offset = (saw_digit || saw_zero) ? end_pos : 9'd0;
            end
            clear_parse();
        end
    endtask

    // Send one text item, in bursts with gaps unless steady_send is set; called and left at a falling edge.
    task automatic push_text(input logic [7:0] b, input bit f,
                             input bit use_typed, input t_parse_result typed);
        int            gap;
        bit            done;
        t_parse_result got;
        if (!steady_send) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 7);
                text_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        text_ch.valid      <= 1'b1;
        text_ch.text_byte  <= b;
        text_ch.final_byte <= f;
        @(posedge clk);
        while (!text_ch.ready) @(posedge clk);
        text_items++;
        parse_step(b, f, done, got);
        if (done) begin
            awaited_numbers.push_back(use_typed ? typed : got);
        end
        @(negedge clk);
    endtask

    // Write the radix register once the parser has gone idle.
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        text_ch.valid <= 1'b0;
        while (awaited_numbers.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.radix <= r;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        radix_reg = r;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic add_string(input string s, input bit nul_end, input bit typed,
                              input t_parse_result want);
        t_row row;
        for (int i = 0; i < s.len(); i++) begin
            row.kind  = ROW_TEXT;
            row.value = s[i];
            row.fin   = !nul_end && (i == s.len() - 1);
            row.typed = typed && row.fin;
            row.want  = want;
            directed_rows.push_back(row);
        end
        if (nul_end) begin
            row.kind  = ROW_TEXT;
            row.value = CH_NUL;
            row.fin   = 1'b0;
            row.typed = typed;
            row.want  = want;
            directed_rows.push_back(row);
        end
    endtask

    task automatic add_radix(input logic [RADIX_W-1:0] r);
        t_row row;
        row.kind  = ROW_RADIX;
        row.value = 8'(r);
        row.fin   = 1'b0;
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endtask

    // A random character that is a digit below the given base.
    function automatic logic [7:0] digit_char(input int base);
        int v;
        v = $urandom_range(0, base - 1);
        if (v < 10) begin
            return CH_DIGIT0 + 8'(v);
        end else if ($urandom_range(0, 1) == 0) begin
            return CH_LOWER_A + 8'(v - 10);
        end
        return CH_UPPER_A + 8'(v - 10);
    endfunction

    // Build and send one random string: mostly well-formed numbers, some noise.
    task automatic send_random_string(input bit go_long);
        logic [7:0] txt[$];
        int         kind;
        int         n;
        int         eff;
        logic [7:0] b;
        bit         nul_end;
        kind = go_long ? 10 : $urandom_range(0, 99);
        if (kind < 10) begin
            // Noise: any byte, final flag at random, closed by a final byte.
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                push_text(8'($urandom_range(0, 255)),
                          (i == n - 1) || ($urandom_range(0, 7) == 0), 1'b0, '0);
            end
        end else begin
            if (kind == 10) begin
                // Long run of zeros that can cross the length limit.
                eff = (radix_reg == RADIX_AUTO || base_unusable(radix_reg)) ? 8
                                                                            : int'(radix_reg);
                n = $urandom_range(250, 262);
                repeat (n) txt.push_back(CH_DIGIT0);
                repeat ($urandom_range(1, 8)) txt.push_back(digit_char(eff));
            end else begin
                repeat ($urandom_range(0, 3)) begin
                    b = 8'($urandom_range(CH_TAB, CH_CR + 1));
                    if (b > CH_CR) b = CH_SPACE;
                    txt.push_back(b);
                end
                case ($urandom_range(0, 3))
                    0: txt.push_back(CH_MINUS);
                    1: txt.push_back(CH_PLUS);
                    default: begin
                    end
                endcase
                eff = int'(radix_reg);
                if (radix_reg == RADIX_AUTO) begin
                    case ($urandom_range(0, 3))
                        0: eff = 10;
                        1: begin
                            txt.push_back(CH_DIGIT0);
                            eff = 8;
                        end
                        default: begin
                            txt.push_back(CH_DIGIT0);
                            txt.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
                            eff = 16;
                        end
                    endcase
                end
                if (base_unusable(RADIX_W'(eff))) eff = 10;
                if ($urandom_range(0, 3) == 0) begin
                    n = $urandom_range(12, (eff < 8) ? 70 : 26);
                end else begin
                    n = $urandom_range(0, 8);
                end
                repeat (n) txt.push_back(digit_char(eff));
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(1, 255)));
                end
            end
            nul_end = (txt.size() == 0) || ($urandom_range(0, 2) == 0);
            foreach (txt[i]) begin
                push_text(txt[i], !nul_end && (i == txt.size() - 1), 1'b0, '0);
            end
            if (nul_end) begin
                push_text(CH_NUL, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
        end
    endtask

    // Receiver: ready stalls on a pattern of its own, with calm stretches.
    initial begin
        int stall_left;
        int cyc;
        stall_left = 0;
        cyc        = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            cyc++;
            if ((cyc % 3000) < 400) begin
                result_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk) begin
        t_parse_result exp_r;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (awaited_numbers.size() == 0) begin
                $error("result item with no expectation: number %h status %0d offset %0d",
                       result_ch.number, result_ch.status, result_ch.stop_offset);
                mismatch_count++;
            end else begin
                exp_r = awaited_numbers.pop_front();
                if (result_ch.number !== exp_r.number) begin
                    $error("number: expected %h, actual %h", exp_r.number, result_ch.number);
                    mismatch_count++;
                end
                if (result_ch.status !== exp_r.status) begin
                    $error("status: expected %0d, actual %0d", exp_r.status, result_ch.status);
                    mismatch_count++;
                end
                if (result_ch.stop_offset !== exp_r.stop_offset) begin
                    $error("stop_offset: expected %0d, actual %0d",
                           exp_r.stop_offset, result_ch.stop_offset);
                    mismatch_count++;
                end
            end
        end
    end

    // Reset, directed table, random phases, drain and verdict.
    initial begin
        logic [RADIX_W-1:0] radix_plan[14];
        int                 start_items;
        text_ch.valid      = 1'b0;
        text_ch.text_byte  = '0;
        text_ch.final_byte = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.radix       = '0;
        rst_n              = 1'b0;
        mismatch_count     = 0;
        text_items         = 0;
        burst_left         = 0;
        steady_send        = 1'b0;
        radix_reg          = RADIX_AUTO;
        clear_parse();

        // Directed table; typed expectations only where they are plain.
        add_string("", 1'b1, 1'b1, '{64'd0, ST_OK, 9'd0});
        add_string("-", 1'b0, 1'b1, '{64'd0, ST_OK, 9'd0});
        add_string("-0", 1'b0, 1'b1, '{64'd0, ST_OK, 9'd2});
        add_string("0x", 1'b0, 1'b1, '{64'd0, ST_OK, 9'd0});
        add_string("\t+7", 1'b0, 1'b1, '{64'd7, ST_OK, 9'd3});
        add_string("-1", 1'b0, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, ST_OK, 9'd2});
        add_string("0XfF", 1'b0, 1'b1, '{64'd255, ST_OK, 9'd4});
        add_string("017", 1'b1, 1'b0, '0);
        add_radix(RADIX_ONE);
        add_string("5", 1'b0, 1'b1, '{64'd0, ST_BAD_RADIX, 9'd0});
        add_radix(6'd63);
        add_string("5", 1'b0, 1'b1, '{64'd0, ST_BAD_RADIX, 9'd0});
        add_radix(RADIX_MAX);
        add_string("zzzzzzzzzzzzz", 1'b0, 1'b1, '{64'd0, ST_OVERFLOW, 9'd13});
        add_radix(6'd2);
        add_string("12", 1'b0, 1'b0, '0);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_RADIX) begin
                write_radix(RADIX_W'(directed_rows[i].value));
            end else begin
                push_text(directed_rows[i].value, directed_rows[i].fin,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases, each under its own radix setting.
        radix_plan = '{RADIX_AUTO, 6'd2, RADIX_MAX, RADIX_DECIMAL, RADIX_HEX, RADIX_OCTAL,
                       RADIX_ONE, 6'd63, RADIX_AUTO, 6'd2, 6'd37, RADIX_AUTO, 6'd0, RADIX_MAX};
        radix_plan[9]  = RADIX_W'($urandom_range(2, 35));
        radix_plan[12] = RADIX_W'($urandom_range(0, 63));
        foreach (radix_plan[p]) begin
            write_radix(radix_plan[p]);
            steady_send = (p == 3) || (p == 9);
            start_items = text_items;
            send_random_string(p == 3);
            while (text_items - start_items < PHASE_ITEMS) send_random_string(1'b0);
        end

        text_ch.valid <= 1'b0;
        while (awaited_numbers.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && awaited_numbers.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
